>>> rtl/p1305_pkg.sv
// Poly1305 MAC package: shared types, constants and helper functions.
// No dependencies; used by the front end, queue, core, top and testbench.
package p1305_pkg;

   localparam int LIMB_W      = 26;
   localparam int ACC_W       = 27;
   localparam int H_W         = 28;
   localparam int R_W         = 26;
   localparam int R5_W        = 29;
   localparam int PROD_W      = 57;
   localparam int NUM_LIMBS   = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W  = 5;

   localparam logic [31:0] LIMB_MASK = 32'h03ff_ffff;
   localparam logic [31:0] TOP_BIT   = 32'h0100_0000;
   localparam logic [31:0] P_TOP     = 32'h0400_0000;
   localparam logic [31:0] FOLD_MUL  = 32'd5;

   localparam logic [1:0] REG_KEY_R_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_R_HIGH = 2'd1;
   localparam logic [1:0] REG_KEY_S_LOW  = 2'd2;
   localparam logic [1:0] REG_KEY_S_HIGH = 2'd3;

   typedef logic [ACC_W-1:0] acc_limb_type;
   typedef logic [H_W-1:0]   h_limb_type;
   typedef logic [R_W-1:0]   r_limb_type;
   typedef logic [R5_W-1:0]  r5_limb_type;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
      logic        hibit;
      logic        absorb;
      logic        last;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FOLD,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3
   } core_state_type;

   function automatic r_limb_type clamp_limb(input logic [63:0] rl,
                                             input logic [63:0] rh,
                                             input int k);
      logic [63:0] v;
      v = 64'd0;
      case (k)
         0: v = rl & 64'(LIMB_MASK);
         1: v = (rl >> 26) & 64'h3ff_ff03;
         2: v = ((rl >> 52) | (rh << 12)) & 64'h3ff_c0ff;
         3: v = (rh >> 14) & 64'h3f0_3fff;
         4: v = (rh >> 40) & 64'h00f_ffff;
         default: v = 64'd0;
      endcase
      return r_limb_type'(v[R_W-1:0]);
   endfunction

   function automatic logic [LIMB_W-1:0] block_limb(input logic [63:0] lo,
                                                    input logic [63:0] hi,
                                                    input int k);
      logic [63:0] v;
      v = 64'd0;
      case (k)
         0: v = lo;
         1: v = lo >> 26;
         2: v = (lo >> 52) | (hi << 12);
         3: v = hi >> 14;
         4: v = hi >> 40;
         default: v = 64'd0;
      endcase
      return v[LIMB_W-1:0];
   endfunction

endpackage

>>> rtl/p1305_if.sv
// Poly1305 MAC channel interfaces: message words in, tag words out.
// No dependencies.
interface p1305_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_low;
   logic [63:0] block_high;
   logic [4:0]  byte_count;
   logic        last;
   modport source (output valid, block_low, block_high, byte_count, last, input ready);
   modport sink   (input valid, block_low, block_high, byte_count, last, output ready);
endinterface

interface p1305_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] tag_low;
   logic [63:0] tag_high;
   modport source (output valid, tag_low, tag_high, input ready);
   modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

>>> rtl/p1305_front.sv
// Poly1305 front end: accepts message words, pads short blocks, classifies.
// Depends on p1305_pkg and p1305_req_if.
module p1305_front (
   p1305_req_if.sink          req,
   input  logic               queue_full,
   output p1305_pkg::job_slot_type push
);

   logic [127:0] raw;
   logic [127:0] padded;
   logic         full_blk;
   logic [4:0]   n;

   always_comb begin
      n        = req.byte_count;
      full_blk = (n >= 5'd16);
      raw      = {req.block_high, req.block_low};
      padded   = raw;
      if (!full_blk) begin
         for (int k = 0; k < 16; k++) begin
            if (5'(k) > n) padded[8*k +: 8] = 8'h00;
            else if (5'(k) == n) padded[8*k +: 8] = 8'h01;
         end
      end
   end

   assign req.ready = !queue_full;

   always_comb begin
      push.job.lo     = padded[63:0];
      push.job.hi     = padded[127:64];
      push.job.hibit  = full_blk;
      push.job.absorb = (n != 5'd0);
      push.job.last   = req.last;
      push.valid      = req.valid && !queue_full && ((n != 5'd0) || req.last);
   end

endmodule

>>> rtl/p1305_fifo.sv
// Poly1305 job queue between front end and multiply core.
// Depends on p1305_pkg.
module p1305_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  p1305_pkg::job_slot_type  push,
   input  logic                     pop,
   output logic                     full,
   output p1305_pkg::job_slot_type  head
);

   localparam int PTR_W = $clog2(p1305_pkg::QUEUE_DEPTH);

   p1305_pkg::job_type mem_ff [p1305_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == (PTR_W+1)'(p1305_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(p1305_pkg::QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(p1305_pkg::QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) count_in = count_ff + 1'b1;
      else if (!push.valid && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) mem_ff[wr_ptr_ff] <= push.job;
   end

endmodule

>>> rtl/p1305_core.sv
// Poly1305 back end: limb-row multiply mod 2^130-5, final reduce, tag add.
// Depends on p1305_pkg and p1305_rsp_if.
module p1305_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [63:0]             key_r_low,
   input  logic [63:0]             key_r_high,
   input  logic [63:0]             key_s_low,
   input  logic [63:0]             key_s_high,
   input  p1305_pkg::job_slot_type head,
   output logic                    pop,
   p1305_rsp_if.source             rsp
);

   localparam int N = p1305_pkg::NUM_LIMBS;

   p1305_pkg::core_state_type state_ff, state_in;
   logic [2:0]                row_ff, row_in;
   logic                      last_ff, last_in;

   p1305_pkg::acc_limb_type acc_ff [N];
   p1305_pkg::acc_limb_type acc_in [N];
   p1305_pkg::h_limb_type   h_ff   [N];
   p1305_pkg::h_limb_type   h_in   [N];
   p1305_pkg::r_limb_type   r_ff   [N];
   p1305_pkg::r_limb_type   r_in   [N];
   p1305_pkg::r5_limb_type  r5_ff  [N];
   p1305_pkg::r5_limb_type  r5_in  [N];
   logic [37:0]             carry_ff, carry_in;
   logic [31:0]             f_ff   [N];
   logic [31:0]             f_in   [N];
   logic [63:0]             lo_ff, lo_in, hi_ff, hi_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [63:0]             tag_lo_ff, tag_lo_in, tag_hi_ff, tag_hi_in;

   logic [p1305_pkg::PROD_W-1:0] prod [N];
   logic [63:0]                  row_sum;
   logic [63:0]                  fold;
   logic [31:0]                  t [N];
   logic [31:0]                  g [N];
   logic [31:0]                  c;
   logic [31:0]                  mask;
   logic [63:0]                  sum_lo;
   logic                         out_free;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.tag_low  = tag_lo_ff;
   assign rsp.tag_high = tag_hi_ff;
   assign out_free     = !rsp_valid_ff || rsp.ready;

   always_comb begin
      for (int j = 0; j < N; j++) begin
         if (row_ff >= 3'(j)) begin
            prod[j] = p1305_pkg::PROD_W'(h_ff[j]) * p1305_pkg::PROD_W'(r_ff[3'(row_ff - 3'(j))]);
         end else begin
            prod[j] = p1305_pkg::PROD_W'(h_ff[j]) *
                      p1305_pkg::PROD_W'(r5_ff[3'(row_ff + 3'(N - j))]);
         end
      end
      row_sum = 64'(carry_ff);
      for (int j = 0; j < N; j++) row_sum = row_sum + 64'(prod[j]);
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      carry_in     = carry_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      tag_lo_in    = tag_lo_ff;
      tag_hi_in    = tag_hi_ff;
      pop          = 1'b0;
      fold         = 64'd0;
      sum_lo       = 64'd0;
      c            = 32'd0;
      mask         = 32'd0;
      for (int k = 0; k < N; k++) begin
         acc_in[k] = acc_ff[k];
         h_in[k]   = h_ff[k];
         r_in[k]   = r_ff[k];
         r5_in[k]  = r5_ff[k];
         f_in[k]   = f_ff[k];
         t[k]      = 32'd0;
         g[k]      = 32'd0;
      end

      case (state_ff)
         p1305_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               last_in  = head.job.last;
               row_in   = 3'd0;
               carry_in = '0;
               for (int k = 0; k < N; k++) begin
                  h_in[k]  = p1305_pkg::H_W'(acc_ff[k]) +
                             p1305_pkg::H_W'(p1305_pkg::block_limb(head.job.lo, head.job.hi, k));
                  r_in[k]  = p1305_pkg::clamp_limb(key_r_low, key_r_high, k);
                  r5_in[k] = p1305_pkg::R5_W'(r_in[k]) * p1305_pkg::R5_W'(p1305_pkg::FOLD_MUL);
               end
               h_in[4] = p1305_pkg::H_W'(acc_ff[4]) +
                         p1305_pkg::H_W'(head.job.hi[63:40]) +
                         (head.job.hibit ? p1305_pkg::H_W'(p1305_pkg::TOP_BIT) : '0);
               if (head.job.absorb) state_in = p1305_pkg::ST_MUL;
               else state_in = p1305_pkg::ST_FIN1;
            end
         end
         p1305_pkg::ST_MUL: begin
            acc_in[3'(row_ff)] = p1305_pkg::ACC_W'(row_sum[p1305_pkg::LIMB_W-1:0]);
            carry_in = row_sum[p1305_pkg::LIMB_W +: 38];
            row_in   = row_ff + 3'd1;
            if (row_ff == 3'(N-1)) state_in = p1305_pkg::ST_FOLD;
         end
         p1305_pkg::ST_FOLD: begin
            fold      = 64'(acc_ff[0]) + 64'(carry_ff) * 64'(p1305_pkg::FOLD_MUL);
            acc_in[0] = p1305_pkg::ACC_W'(fold[p1305_pkg::LIMB_W-1:0]);
            acc_in[1] = acc_ff[1] + p1305_pkg::ACC_W'(fold >> p1305_pkg::LIMB_W);
            state_in  = last_ff ? p1305_pkg::ST_FIN1 : p1305_pkg::ST_IDLE;
         end
         p1305_pkg::ST_FIN1: begin
            for (int k = 0; k < N; k++) t[k] = 32'(acc_ff[k]);
            c = t[1] >> 26; t[1] = t[1] & p1305_pkg::LIMB_MASK;
            t[2] = t[2] + c; c = t[2] >> 26; t[2] = t[2] & p1305_pkg::LIMB_MASK;
            t[3] = t[3] + c; c = t[3] >> 26; t[3] = t[3] & p1305_pkg::LIMB_MASK;
            t[4] = t[4] + c; c = t[4] >> 26; t[4] = t[4] & p1305_pkg::LIMB_MASK;
            t[0] = t[0] + c * p1305_pkg::FOLD_MUL; c = t[0] >> 26;
            t[0] = t[0] & p1305_pkg::LIMB_MASK;
            t[1] = t[1] + c;
            for (int k = 0; k < N; k++) f_in[k] = t[k];
            state_in = p1305_pkg::ST_FIN2;
         end
         p1305_pkg::ST_FIN2: begin
            g[0] = f_ff[0] + p1305_pkg::FOLD_MUL; c = g[0] >> 26;
            g[0] = g[0] & p1305_pkg::LIMB_MASK;
            g[1] = f_ff[1] + c; c = g[1] >> 26; g[1] = g[1] & p1305_pkg::LIMB_MASK;
            g[2] = f_ff[2] + c; c = g[2] >> 26; g[2] = g[2] & p1305_pkg::LIMB_MASK;
            g[3] = f_ff[3] + c; c = g[3] >> 26; g[3] = g[3] & p1305_pkg::LIMB_MASK;
            g[4] = f_ff[4] + c - p1305_pkg::P_TOP;
            mask = (g[4] >> 31) - 32'd1;
            for (int k = 0; k < N; k++) t[k] = (f_ff[k] & ~mask) | (g[k] & mask);
            lo_in = 64'(t[0]) | (64'(t[1]) << 26) | (64'(t[2]) << 52);
            hi_in = 64'(t[2] >> 12) | (64'(t[3]) << 14) | (64'(t[4]) << 40);
            state_in = p1305_pkg::ST_FIN3;
         end
         p1305_pkg::ST_FIN3: begin
            if (out_free) begin
               sum_lo       = lo_ff + key_s_low;
               tag_lo_in    = sum_lo;
               tag_hi_in    = hi_ff + key_s_high + 64'(sum_lo < lo_ff);
               rsp_valid_in = 1'b1;
               for (int k = 0; k < N; k++) acc_in[k] = '0;
               state_in = p1305_pkg::ST_IDLE;
            end
         end
         default: state_in = p1305_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= p1305_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < N; k++) acc_ff[k] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < N; k++) acc_ff[k] <= acc_in[k];
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      last_ff   <= last_in;
      carry_ff  <= carry_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      tag_lo_ff <= tag_lo_in;
      tag_hi_ff <= tag_hi_in;
      for (int k = 0; k < N; k++) begin
         h_ff[k]  <= h_in[k];
         r_ff[k]  <= r_in[k];
         r5_ff[k] <= r5_in[k];
         f_ff[k]  <= f_in[k];
      end
   end

endmodule

>>> rtl/poly1305_mac.sv
// Poly1305 one-time authenticator. Each accepted word with a nonzero byte
// count absorbs one block of up to 16 bytes; a word with last set yields the
// 16-byte tag and clears the state. An absorbing word occupies the multiply
// core for a load, five limb rows of five 28x26 or 28x29 products, one row
// per cycle, and a carry fold; a closing word adds final reduction and pad
// addition, which a closing word with no block reaches straight from the
// load. Pad addition waits while a previous tag is still held. A two-entry
// queue and the tag register let input and output stall independently.
// Key registers at byte addresses 0, 8, 16, 24 (r low, r high, s low, s high).
// Depends on p1305_pkg, p1305_if, p1305_front, p1305_fifo, p1305_core.
module poly1305_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   p1305_req_if.sink                            req,
   p1305_rsp_if.source                          rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [p1305_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [63:0]                          csr_pwdata,
   output logic [63:0]                          csr_prdata,
   output logic                                 csr_pready
);

   logic [63:0] key_r_low_ff, key_r_high_ff, key_s_low_ff, key_s_high_ff;
   logic [1:0]  reg_idx;
   logic        wr_en;

   p1305_pkg::job_slot_type push;
   p1305_pkg::job_slot_type head;
   logic                    queue_full;
   logic                    pop;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_r_low_ff  <= '0;
         key_r_high_ff <= '0;
         key_s_low_ff  <= '0;
         key_s_high_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            p1305_pkg::REG_KEY_R_LOW:  key_r_low_ff  <= csr_pwdata;
            p1305_pkg::REG_KEY_R_HIGH: key_r_high_ff <= csr_pwdata;
            p1305_pkg::REG_KEY_S_LOW:  key_s_low_ff  <= csr_pwdata;
            p1305_pkg::REG_KEY_S_HIGH: key_s_high_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         p1305_pkg::REG_KEY_R_LOW:  csr_prdata = key_r_low_ff;
         p1305_pkg::REG_KEY_R_HIGH: csr_prdata = key_r_high_ff;
         p1305_pkg::REG_KEY_S_LOW:  csr_prdata = key_s_low_ff;
         p1305_pkg::REG_KEY_S_HIGH: csr_prdata = key_s_high_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   p1305_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .push       (push)
   );

   p1305_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   p1305_core u_core (
      .clock      (clock),
      .reset      (reset),
      .key_r_low  (key_r_low_ff),
      .key_r_high (key_r_high_ff),
      .key_s_low  (key_s_low_ff),
      .key_s_high (key_s_high_ff),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

>>> bench/p1305_tb_pkg.sv
`timescale 1ns / 1ps
// Bench-side Poly1305 tag predictor: clamp, absorb and finish in 130-bit math.
// Depends on nothing; used by the testbench top.
package p1305_tb_pkg;

   localparam logic [129:0] PRIME = (130'd1 << 130) - 130'd5;

   function automatic logic [129:0] clamp_key_r(input logic [63:0] rl, input logic [63:0] rh);
      logic [127:0] r;
      r = {rh, rl} & 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;
      return {2'b00, r};
   endfunction

   // padded block value for a given count, 0 when no block
   function automatic logic [129:0] pad_block(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [4:0] n);
      logic [127:0] b;
      logic [127:0] m;
      b = {hi, lo};
      if (n >= 5'd16) return {2'b01, b};
      if (n == 5'd0) return 130'd0;
      m = (128'd1 << (8 * n)) - 128'd1;
      return {2'b00, (b & m) | (128'd1 << (8 * n))};
   endfunction

   function automatic logic [129:0] absorb_block(input logic [129:0] h, input logic [129:0] blk,
                                                 input logic [129:0] r);
      logic [260:0] p;
      p = (261'(h) + 261'(blk)) * 261'(r);
      return 130'(p % 261'(PRIME));
   endfunction

   function automatic logic [127:0] tag_of(input logic [129:0] h, input logic [127:0] s);
      return h[127:0] + s;
   endfunction

endpackage

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Top-level bench for poly1305_mac: directed and random keys and messages,
// APB key writes, tags checked in order against a 130-bit arithmetic predictor.
module testbench;

   logic clock = 0, reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [p1305_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;

   p1305_req_if req ();
   p1305_rsp_if rsp ();

   poly1305_mac dut (.clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready));

   logic [63:0] key_reg [4];
   logic [129:0] acc_h = '0;
   logic [127:0] tag_queue [$];
   int errors = 0, tags_seen = 0, words_sent = 0, cycles = 0;
   int hold_cycles = 0;
   bit rand_stall = 0;

   initial forever #5 clock = ~clock;

   initial begin
      req.valid = 0; req.block_low = '0; req.block_high = '0;
      req.byte_count = '0; req.last = 0; rsp.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic report(input string what, input logic [127:0] got, input logic [127:0] exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      errors++;
   endtask

   // receiver: random stalls when rand_stall set, plus long hold-off while hold_cycles set
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (tag_queue.size() == 0) report("unexpected tag", {rsp.tag_high, rsp.tag_low}, '0);
         else begin
            logic [127:0] e;
            e = tag_queue.pop_front();
            if (rsp.tag_low !== e[63:0]) report("tag_low", rsp.tag_low, e[63:0]);
            if (rsp.tag_high !== e[127:64]) report("tag_high", rsp.tag_high, e[127:64]);
         end
         tags_seen++;
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 0;
      end else if (rand_stall) begin
         if ($urandom_range(0, 49) == 0) begin
            hold_cycles <= $urandom_range(10, 40);
            rsp.ready <= 0;
         end else rsp.ready <= ($urandom_range(0, 9) < 7);
      end else rsp.ready <= 1;
   end

   task automatic write_key(input logic [1:0] idx, input logic [63:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= p1305_pkg::CSR_ADDR_W'(idx) << 3; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      key_reg[idx] = v;
   endtask

   task automatic wait_idle();
      while (tag_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] rl, rh, sl, sh);
      wait_idle();
      write_key(p1305_pkg::REG_KEY_R_LOW, rl);
      write_key(p1305_pkg::REG_KEY_R_HIGH, rh);
      write_key(p1305_pkg::REG_KEY_S_LOW, sl);
      write_key(p1305_pkg::REG_KEY_S_HIGH, sh);
   endtask

   task automatic send_word(input logic [63:0] lo, hi, input logic [4:0] n, input bit fin);
      int gap;
      logic [129:0] r;
      if (rand_stall) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         if (gap > 0) begin
            req.valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      req.valid <= 1; req.block_low <= lo; req.block_high <= hi;
      req.byte_count <= n; req.last <= fin;
      do @(posedge clock); while (!req.ready);
      r = p1305_tb_pkg::clamp_key_r(key_reg[0], key_reg[1]);
      if (n != 0) acc_h = p1305_tb_pkg::absorb_block(acc_h, p1305_tb_pkg::pad_block(lo, hi, n), r);
      if (fin) begin
         tag_queue.push_back(p1305_tb_pkg::tag_of(acc_h, {key_reg[3], key_reg[2]}));
         acc_h = '0;
      end
      words_sent++;
   endtask

   task automatic end_send();
      req.valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      load_key('0, '0, '0, '0);
      send_word('0, '0, 5'd0, 1);
      end_send();
      load_key('1, '1, '1, '1);
      send_word('1, '1, 5'd16, 0);
      send_word('1, '1, 5'd16, 1);
      send_word('1, '1, 5'd31, 1);
      send_word('1, '1, 5'd17, 0);
      send_word('1, '1, 5'd0, 1);
      for (int n = 1; n < 16; n++) send_word('1, '1, 5'(n), n[0]);
      send_word('1, '1, 5'd8, 1);
      send_word('0, '0, 5'd0, 1);
      end_send();
      load_key(rnd64(), rnd64(), rnd64(), rnd64());
      send_word(rnd64(), rnd64(), 5'd16, 1);
      end_send();
   endtask

   task automatic test_random();
      rand_stall = 1;
      for (int m = 0; m < 165; m++) begin
         int len;
         if (m % 30 == 29) begin
            end_send();
            case (m / 30)
               0: load_key('0, '1, '1, '0);
               default: load_key(rnd64(), rnd64(), rnd64(), rnd64());
            endcase
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
         for (int i = 0; i < len; i++)
            send_word(rnd64(), rnd64(), ($urandom_range(0, 3) == 0) ?
                      5'($urandom_range(0, 31)) : 5'd16, 0);
         send_word(rnd64(), rnd64(), 5'($urandom_range(0, 16)), 1);
      end
      end_send();
   endtask

   task automatic test_pressure();
      hold_cycles = 300;
      for (int i = 0; i < 12; i++) send_word(rnd64(), rnd64(), 5'($urandom_range(0, 31)), 1);
      end_send();
      wait_idle();
      for (int i = 0; i < 6; i++) send_word(rnd64(), rnd64(), 5'd16, i == 5);
      end_send();
   endtask

   initial begin
      key_reg[0] = '0; key_reg[1] = '0; key_reg[2] = '0; key_reg[3] = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random();
      test_pressure();
      wait_idle();
      $display("covered %0d message words and %0d tags over several keys,", words_sent, tags_seen);
      $display("short, full, oversized and empty blocks, with stalls on both sides");
      if (errors == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule
